[design/olt_pkg.sv]
package olt_pkg;

    // Store geometry
    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 64;

    // Fixed port widths
    localparam int OP_W   = 3;
    localparam int POS_W  = 6;
    localparam int PORT_W = 64;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    // Derived widths
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [IDX_W-1:0]       t_index;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [POS_W-1:0]       t_pos;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_READ      = 3'd1,
        OP_FIND      = 3'd2,
        OP_REMOVE_AT = 3'd3,
        OP_REMOVE_EQ = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic   cmp;       // latch the match flag this cycle
        logic   by_value;  // match on value, else on position
        logic   shift;     // close the gap at and after the first match
        logic   append;    // write value into the cell at index count
        t_pos   pos;
        t_count count;
        t_value value;
    } t_cell_ctrl;

endpackage

[design/ordered_list_table.sv]
// Channel | Direction | Handshake                 | Payload
// request | in        | i_in_valid / o_in_stall   | i_opcode, i_position_in, i_value_in
// result  | out       | o_out_valid / i_out_stall | o_status, o_value_out, o_position_out,
//         |           |                           | o_occupancy
//
// Each transaction passes a compare state, which latches a match flag in every cell of
// the chain, then an update state, which ripples the first match down the chain and
// shifts or appends in place. A new request is taken in the cycle the previous one
// updates. A stalled result holds the update stage until the output frees.
// Synchronous active-low reset clears the count, sequencer and out valid; entries need none.
module ordered_list_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [olt_pkg::OP_W-1:0]      i_opcode,
    input  logic [olt_pkg::POS_W-1:0]     i_position_in,
    input  logic [olt_pkg::PORT_W-1:0]    i_value_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [olt_pkg::STAT_W-1:0]    o_status,
    output logic [olt_pkg::PORT_W-1:0]    o_value_out,
    output logic [olt_pkg::POS_W-1:0]     o_position_out,
    output logic [olt_pkg::OCC_W-1:0]     o_occupancy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    olt_pkg::t_op        r_op;
    olt_pkg::t_pos       r_pos;
    olt_pkg::t_value     r_val;
    olt_pkg::t_count     r_count, n_count;
    logic                r_out_valid, n_out_valid;
    olt_pkg::t_status    r_status, n_status;
    olt_pkg::t_value     r_value_out, n_value_out;
    olt_pkg::t_index     r_position_out, n_position_out;
    olt_pkg::t_count     r_occupancy, n_occupancy;

    olt_pkg::t_cell_ctrl ctrl;
    logic                seen  [olt_pkg::DEPTH+1];
    logic [olt_pkg::DEPTH-1:0] first;
    olt_pkg::t_value     entry [olt_pkg::DEPTH];
    olt_pkg::t_value     rd    [olt_pkg::DEPTH];
    olt_pkg::t_value     rd_bus;
    olt_pkg::t_index     hit_pos;
    logic                any_hit;
    logic                out_free;
    logic                upd_go;
    logic                in_take;
    logic                is_remove;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign upd_go     = (r_state == S_UPD) && out_free;
    assign o_in_stall = !((r_state == S_IDLE) || upd_go);
    assign in_take    = i_in_valid && !o_in_stall;
    assign is_remove  = (r_op == olt_pkg::OP_REMOVE_AT) || (r_op == olt_pkg::OP_REMOVE_EQ);

    // Broadcast control to the chain
    always_comb begin
        ctrl.cmp      = (r_state == S_CMP);
        ctrl.by_value = (r_op == olt_pkg::OP_FIND) || (r_op == olt_pkg::OP_REMOVE_EQ);
        ctrl.shift    = upd_go && is_remove;
        ctrl.append   = upd_go && (r_op == olt_pkg::OP_APPEND);
        ctrl.pos      = r_pos;
        ctrl.count    = r_count;
        ctrl.value    = r_val;
    end

    // Chain of cells
    assign seen[0] = 1'b0;
    for (genvar g = 0; g < olt_pkg::DEPTH; g++) begin : g_cell
        olt_pkg::t_value next_entry;
        if (g == olt_pkg::DEPTH - 1) begin : g_last
            assign next_entry = entry[g];
        end else begin : g_mid
            assign next_entry = entry[g+1];
        end
        olt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_index      (olt_pkg::IDX_W'(g)),
            .i_seen       (seen[g]),
            .i_next_entry (next_entry),
            .o_seen       (seen[g+1]),
            .o_first      (first[g]),
            .o_entry      (entry[g]),
            .o_read       (rd[g])
        );
    end
    assign any_hit = seen[olt_pkg::DEPTH];

    // Encode the first match and collect the read bus
    always_comb begin
        hit_pos = '0;
        rd_bus  = '0;
        for (int k = 0; k < olt_pkg::DEPTH; k++) begin
            hit_pos = hit_pos | (first[k] ? olt_pkg::IDX_W'(k) : '0);
            rd_bus  = rd_bus | rd[k];
        end
    end

    // Sequencer and result formation
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_out_valid    = r_out_valid && i_out_stall;
        n_status       = r_status;
        n_value_out    = r_value_out;
        n_position_out = r_position_out;
        n_occupancy    = r_occupancy;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_state        = in_take ? S_CMP : S_IDLE;
                    n_status       = olt_pkg::ST_OK;
                    n_value_out    = '0;
                    n_position_out = '0;
                    case (r_op)
                        olt_pkg::OP_APPEND: begin
                            if (r_count == olt_pkg::t_count'(olt_pkg::DEPTH)) begin
                                n_status = olt_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        olt_pkg::OP_READ: begin
                            if (any_hit) begin
                                n_value_out = rd_bus;
                            end else begin
                                n_status = olt_pkg::ST_RANGE;
                            end
                        end
                        olt_pkg::OP_FIND: begin
                            if (any_hit) begin
                                n_position_out = hit_pos;
                            end else begin
                                n_status = olt_pkg::ST_NOTFOUND;
                            end
                        end
                        olt_pkg::OP_REMOVE_AT: begin
                            if (any_hit) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                n_status = olt_pkg::ST_RANGE;
                            end
                        end
                        olt_pkg::OP_REMOVE_EQ: begin
                            if (any_hit) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                n_status = olt_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_occupancy = n_count;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Latch request and result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= olt_pkg::t_op'(i_opcode);
            r_pos <= i_position_in;
            r_val <= olt_pkg::t_value'(i_value_in);
        end
        r_status       <= n_status;
        r_value_out    <= n_value_out;
        r_position_out <= n_position_out;
        r_occupancy    <= n_occupancy;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_value_out    = olt_pkg::PORT_W'(r_value_out);
    assign o_position_out = olt_pkg::POS_W'(r_position_out);
    assign o_occupancy    = olt_pkg::OCC_W'(r_occupancy);

    // Count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= olt_pkg::t_count'(olt_pkg::DEPTH))
        else $error("count exceeds depth");

    // Only one cell can claim the first match
    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(first))
        else $error("more than one first match");

    // A result loaded reports the count after the update
    a_occ_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> (r_occupancy == r_count))
        else $error("occupancy does not match count");

    // An accepted append into a non-full store grows the count by one
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && (r_op == olt_pkg::OP_APPEND) &&
         (r_count != olt_pkg::t_count'(olt_pkg::DEPTH)))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow count");

endmodule

[design/olt_cell.sv]
module olt_cell (
    input  logic               i_clk,
    input  olt_pkg::t_cell_ctrl i_ctrl,
    input  olt_pkg::t_index    i_index,
    input  logic               i_seen,
    input  olt_pkg::t_value    i_next_entry,
    output logic               o_seen,
    output logic               o_first,
    output olt_pkg::t_value    o_entry,
    output olt_pkg::t_value    o_read
);

    olt_pkg::t_value r_entry;
    olt_pkg::t_value n_entry;
    logic            r_hit;
    logic            n_hit;
    logic            in_range;
    logic            pos_eq;
    logic            at_tail;

    // Entry is live when its index is below the count
    assign in_range = olt_pkg::t_count'(i_index) < i_ctrl.count;
    assign pos_eq   = olt_pkg::CMP_W'(i_index) == olt_pkg::CMP_W'(i_ctrl.pos);
    assign at_tail  = olt_pkg::t_count'(i_index) == i_ctrl.count;

    // Compare stage: latch match flag
    always_comb begin
        n_hit = r_hit;
        if (i_ctrl.cmp) begin
            if (i_ctrl.by_value) begin
                n_hit = in_range && (r_entry == i_ctrl.value);
            end else begin
                n_hit = in_range && pos_eq;
            end
        end
    end

    // Update stage: take the neighbor's entry at and after the match, or append
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift && (i_seen || r_hit)) begin
            n_entry = i_next_entry;
        end else if (i_ctrl.append && at_tail) begin
            n_entry = i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_entry <= n_entry;
    end

    // Pass the seen flag down the chain
    assign o_seen  = i_seen || r_hit;
    assign o_first = r_hit && !i_seen;
    assign o_entry = r_entry;
    assign o_read  = r_hit ? r_entry : '0;

endmodule
